>>> sv/imu_caf_pkg.sv
`default_nettype none
package imu_caf_pkg;

    // cordic iteration count, capped at 24; the angle table holds 19 nonzero entries
    localparam int CordicSteps = 16;
    localparam int CordicIters = (CordicSteps < 24) ? CordicSteps : 24;
    localparam int IterW = 5;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_SCALE  = 3'd1;
    localparam logic [2:0] REG_BIAS_X = 3'd2;
    localparam logic [2:0] REG_BIAS_Y = 3'd3;
    localparam logic [2:0] REG_BIAS_Z = 3'd4;
    localparam logic [2:0] REG_ALPHA  = 3'd5;

    localparam logic signed [39:0] HalfPiQ18  = 40'sd411775;
    localparam logic [15:0]        InvGainQ16 = 16'd39797;
    localparam logic [16:0]        OneQ16     = 17'd65536;

    // cordic datapath width: 24-bit operands can grow by the gain and one bit more
    localparam int CW = 30;

    function automatic logic signed [39:0] atan_q18(input logic [IterW-1:0] i);
        logic signed [39:0] r;
        begin
            case (i)
                5'd0:  r = 40'sd205887;
                5'd1:  r = 40'sd121542;
                5'd2:  r = 40'sd64220;
                5'd3:  r = 40'sd32599;
                5'd4:  r = 40'sd16363;
                5'd5:  r = 40'sd8189;
                5'd6:  r = 40'sd4096;
                5'd7:  r = 40'sd2048;
                5'd8:  r = 40'sd1024;
                5'd9:  r = 40'sd512;
                5'd10: r = 40'sd256;
                5'd11: r = 40'sd128;
                5'd12: r = 40'sd64;
                5'd13: r = 40'sd32;
                5'd14: r = 40'sd16;
                5'd15: r = 40'sd8;
                5'd16: r = 40'sd4;
                5'd17: r = 40'sd2;
                5'd18: r = 40'sd1;
                default: r = 40'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/imu_complementary_attitude_filter.sv
// channel | valid         | ready         | payload
// cfg     | cfg_valid     | cfg_ready     | cfg_index, cfg_data
// in      | in_valid      | in_ready      | accel_x/y/z, gyro_x/y/z, step_time
// out     | out_valid     | out_ready     | roll/pitch_angle_out, rate_x/y/z_out
// an enabled sample raises out_valid after three rate products, two cordic passes of one
// iteration a cycle with a magnitude scaling between them, and six blend steps; the rate
// products, the scaling and the blend steps share the one multiplier. a pass whose vector
// is zero is skipped. the next input beat is taken the cycle after the result beat.
// a beat taken while disabled is dropped at once with no result.
// reset clears the registers to their defaults and the angles to zero.
// the result register holds until out_ready; input waits while a cfg beat is offered.
`default_nettype none
module imu_complementary_attitude_filter
    import imu_caf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    input  wire logic [15:0]        step_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [19:0]      roll_angle_out,
    output logic signed [19:0]      pitch_angle_out,
    output logic signed [20:0]      rate_x_out,
    output logic signed [20:0]      rate_y_out,
    output logic signed [20:0]      rate_z_out
);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RATE  = 4'd1;  // three gyro products
    localparam logic [3:0] S_C1PRE = 4'd2;
    localparam logic [3:0] S_C1    = 4'd3;
    localparam logic [3:0] S_MAG   = 4'd4;
    localparam logic [3:0] S_C2PRE = 4'd5;
    localparam logic [3:0] S_C2    = 4'd6;
    localparam logic [3:0] S_BLEND = 4'd7;  // multiply steps for the blend
    localparam logic [3:0] S_DONE  = 4'd8;

    // configuration registers
    logic               enable_reg;
    logic [23:0]        scale_reg;
    logic signed [20:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic [16:0]        alpha_reg;

    logic [3:0]         state_reg;
    logic [IterW-1:0]   cnt_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0]        dt_reg;
    logic signed [20:0] rx_reg, ry_reg, rz_reg;
    logic signed [19:0] roll_reg, pitch_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [39:0] cz_reg;
    logic signed [19:0] acc_roll_reg;
    logic signed [42:0] acc_reg;     // blend accumulator
    logic signed [42:0] pred_reg;
    logic               out_valid_reg;

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg && !cfg_valid;
    assign out_valid = out_valid_reg;
    assign roll_angle_out  = roll_reg;
    assign pitch_angle_out = pitch_reg;
    assign rate_x_out = rx_reg;
    assign rate_y_out = ry_reg;
    assign rate_z_out = rz_reg;

    // shared multiplier, operands chosen by the sequencer
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    function automatic logic signed [20:0] sat21(input logic signed [47:0] v);
        begin
            if (v > 48'sd1048575)       return 21'sd1048575;
            else if (v < -48'sd1048576) return -21'sd1048576;
            else                        return v[20:0];
        end
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [67:0] v);
        begin
            if (v > 68'sd524287)       return 20'sd524287;
            else if (v < -68'sd524288) return -20'sd524288;
            else                       return v[19:0];
        end
    endfunction

    // cordic stage
    logic signed [CW-1:0] dx, dy;
    logic                 ypos;
    assign dx   = cy_reg >>> cnt_reg;
    assign dy   = cx_reg >>> cnt_reg;
    assign ypos = !cy_reg[CW-1];

    // cordic pre-rotation from operands x, y
    logic signed [CW-1:0] pre_x, pre_y, px, py;
    logic signed [39:0]   pz;
    logic                 pzero;
    always_comb
    begin
        px = pre_x;
        py = pre_y;
        pz = '0;
        pzero = (pre_x == '0) && (pre_y == '0);
        if (pre_x[CW-1]) begin
            if (!pre_y[CW-1]) begin
                px = pre_y; py = -pre_x; pz = HalfPiQ18;
            end else begin
                px = -pre_y; py = pre_x; pz = -HalfPiQ18;
            end
        end
    end

    logic signed [39:0] zr;
    logic signed [19:0] cz_ang;
    assign zr     = (cz_reg + 40'sd2) >>> 2;
    assign cz_ang = zr[19:0];

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        pre_x = '0;
        pre_y = '0;
        case (state_reg)
            S_RATE:
            begin
                case (cnt_reg)
                    5'd0:    mul_a = 32'(gx_reg);
                    5'd1:    mul_a = 32'(gy_reg);
                    default: mul_a = 32'(gz_reg);
                endcase
                mul_b = $signed({1'b0, scale_reg});
            end
            S_C1PRE:
            begin
                pre_x = {{(CW-24){az_reg[15]}}, az_reg, 8'd0};
                pre_y = {{(CW-24){ay_reg[15]}}, ay_reg, 8'd0};
            end
            S_MAG:
            begin
                mul_a = 32'(cx_reg);
                mul_b = $signed({9'd0, InvGainQ16});
            end
            S_C2PRE:
            begin
                pre_x = cx_reg;
                pre_y = -{{(CW-24){ax_reg[15]}}, ax_reg, 8'd0};
            end
            S_BLEND:
            begin
                // steps: 0 roll rate*dt, 1 pitch rate*dt, 2..5 alpha products
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = 32'(rx_reg); mul_b = $signed({9'd0, dt_reg});
                    end
                    5'd1:
                    begin
                        mul_a = 32'(ry_reg); mul_b = $signed({9'd0, dt_reg});
                    end
                    5'd2:
                    begin
                        mul_a = 32'(pred_reg); mul_b = $signed({8'd0, alpha_reg});
                    end
                    5'd3:
                    begin
                        mul_a = 32'(acc_roll_reg);
                        mul_b = $signed({8'd0, OneQ16 - alpha_reg});
                    end
                    5'd4:
                    begin
                        mul_a = 32'(cz_ang);
                        mul_b = $signed({8'd0, OneQ16 - alpha_reg});
                    end
                    default:
                    begin
                        // alpha times the pitch prediction
                        mul_a = 32'(pred_reg); mul_b = $signed({8'd0, alpha_reg});
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    logic signed [67:0] rnd16;
    assign rnd16 = (mul_p + 68'sd32768) >>> 16;

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg    <= 1'b0;
            scale_reg     <= 24'd1143750;
            bias_x_reg    <= '0;
            bias_y_reg    <= '0;
            bias_z_reg    <= '0;
            alpha_reg     <= 17'd64225;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            // configuration beat
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_SCALE:  scale_reg  <= cfg_data;
                    REG_BIAS_X: bias_x_reg <= cfg_data[20:0];
                    REG_BIAS_Y: bias_y_reg <= cfg_data[20:0];
                    REG_BIAS_Z: bias_z_reg <= cfg_data[20:0];
                    REG_ALPHA:  alpha_reg  <= (cfg_data[16:0] > OneQ16) ? OneQ16
                                                                      : cfg_data[16:0];
                    default:    enable_reg <= enable_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready && enable_reg) begin
                        ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
                        gx_reg <= gyro_x;  gy_reg <= gyro_y;  gz_reg <= gyro_z;
                        dt_reg <= step_time;
                        cnt_reg   <= '0;
                        state_reg <= S_RATE;
                    end
                end
                S_RATE:
                begin
                    case (cnt_reg)
                        5'd0:    rx_reg <= sat21(rnd16[47:0] - 48'(bias_x_reg));
                        5'd1:    ry_reg <= sat21(rnd16[47:0] - 48'(bias_y_reg));
                        default: rz_reg <= sat21(rnd16[47:0] - 48'(bias_z_reg));
                    endcase
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd2)
                        state_reg <= S_C1PRE;
                end
                S_C1PRE, S_C2PRE:
                begin
                    cx_reg  <= px;
                    cy_reg  <= py;
                    cz_reg  <= pz;
                    cnt_reg <= '0;
                    if (pzero) begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        state_reg <= (state_reg == S_C1PRE) ? S_MAG : S_BLEND;
                        if (state_reg == S_C1PRE)
                            acc_roll_reg <= '0;
                    end else begin
                        state_reg <= (state_reg == S_C1PRE) ? S_C1 : S_C2;
                    end
                end
                S_C1, S_C2:
                begin
                    if (ypos) begin
                        cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + atan_q18(cnt_reg);
                    end else begin
                        cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - atan_q18(cnt_reg);
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == IterW'(CordicIters - 1)) begin
                        cnt_reg <= '0;
                        state_reg <= (state_reg == S_C1) ? S_MAG : S_BLEND;
                    end
                end
                S_MAG:
                begin
                    // cz_ang is the roll angle here (zero if the vector was zero)
                    if (cz_reg != '0 || cx_reg != '0)
                        acc_roll_reg <= cz_ang;
                    cx_reg    <= rnd16[CW-1:0];
                    state_reg <= S_C2PRE;
                end
                S_BLEND:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    case (cnt_reg)
                        5'd0:
                        begin
                            pred_reg <= 43'(roll_reg)
                                        + (($signed(mul_p[42:0]) + 43'sd524288) >>> 20);
                        end
                        5'd1:
                        begin
                            acc_reg  <= 43'(pitch_reg)
                                        + (($signed(mul_p[42:0]) + 43'sd524288) >>> 20);
                        end
                        5'd2:
                        begin
                            // swap: pred_reg gets pitch prediction, acc holds roll product
                            pred_reg <= acc_reg;
                            acc_reg  <= mul_p[42:0];
                        end
                        5'd3:
                        begin
                            roll_reg <= sat20((68'(acc_reg) + mul_p + 68'sd32768) >>> 16);
                        end
                        5'd4:
                        begin
                            acc_reg <= mul_p[42:0];
                        end
                        default:
                        begin
                            pitch_reg <= sat20((68'(acc_reg) + mul_p + 68'sd32768) >>> 16);
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(roll_angle_out)))
        else $error("result dropped");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result missing");

endmodule
`default_nettype wire
